FILE: sv/base64_stream_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication.
`define B64D_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define B64D_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Shared widths, result codes and the command format between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    // Width of the saturating byte counter.
    localparam int LENGTH_BITS = 16;
    // Width used to compare the counter against the 16-bit capacity.
    localparam int CMP_W       = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    // Command queue between front and back.
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);

    // Result kinds.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Closing status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // One result item, without its last flag.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [1:0]  status;
        logic [15:0] total_length;
    } t_result;

    // All results caused by one input character, oldest in slot 0.
    typedef struct packed {
        t_result [3:0] res;
        logic [2:0]    n;
    } t_cmd;

    // Queue fill status seen by front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: sv/b64d_front.sv
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Accepts characters, decodes symbols, keeps the message state and forms one
// command holding every result that the character causes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_top_defines.svh"

module b64d_front import b64d_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_final_char,
    input  wire logic        i_cfg_valid,
    input  wire logic [15:0] i_cfg_data,
    input  wire t_q_stat     i_q_stat,
    output      logic        o_cmd_push,
    output      t_cmd        o_cmd
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // Character codes.
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5a;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7a;
    localparam logic [7:0] CH_D0   = 8'h30;
    localparam logic [7:0] CH_D9   = 8'h39;
    localparam logic [7:0] CH_PLUS = 8'h2b;
    localparam logic [7:0] CH_SL   = 8'h2f;
    localparam logic [7:0] CH_EQ   = 8'h3d;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_NUL  = 8'h00;

    // Alphabet lookup: bit 6 flags a valid symbol, bits 5:0 hold its value.
    function automatic logic [6:0] decode_sym(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            v = c - CH_UP_A;
            return {1'b1, v[5:0]};
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            v = c - CH_LO_A + 8'd26;
            return {1'b1, v[5:0]};
        end else if (c >= CH_D0 && c <= CH_D9) begin
            v = c - CH_D0 + 8'd52;
            return {1'b1, v[5:0]};
        end else if (c == CH_PLUS) begin
            return {1'b1, 6'd62};
        end else if (c == CH_SL) begin
            return {1'b1, 6'd63};
        end
        return 7'd0;
    endfunction

    // Saturating add of a small step to the byte counter.
    function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] c,
                                                       input logic [1:0] k);
        logic [LENGTH_BITS+1:0] s;
        s = {2'b00, c} + {{LENGTH_BITS{1'b0}}, k};
        return (s[LENGTH_BITS+1:LENGTH_BITS] != 2'b00) ? LEN_MAX : s[LENGTH_BITS-1:0];
    endfunction

    logic [15:0]            r_capacity;
    logic [23:0]            r_bits, n_bits;
    logic [1:0]             r_sym, n_sym;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic                   r_over, n_over;

    logic       accept;
    logic [6:0] dec;
    logic       is_ws;
    logic [23:0] grp;
    logic [1:0] nb;
    logic [7:0] bsrc [3];
    logic       close_ok;
    logic       invalid;
    logic       has_close;
    logic [LENGTH_BITS-1:0] cnt [4];
    logic [2:0] room;
    logic [1:0] ne;
    logic [LENGTH_BITS-1:0] c_after;
    logic [1:0] st_code;

    assign accept = i_push && !i_q_stat.full;
    assign dec    = decode_sym(i_symbol);
    assign is_ws  = (i_symbol == CH_SP) || (i_symbol == CH_TAB) ||
                    (i_symbol == CH_CR) || (i_symbol == CH_LF);

    // The group with the current symbol placed in its slot.
    always_comb begin
        grp = r_bits;
        case (r_sym)
            2'd0:    grp[23:18] = dec[5:0];
            2'd1:    grp[17:12] = dec[5:0];
            2'd2:    grp[11:6]  = dec[5:0];
            default: grp[5:0]   = dec[5:0];
        endcase
    end

    // Classify the character and work out the group and message state.
    always_comb begin
        nb       = 2'd0;
        bsrc[0]  = r_bits[23:16];
        bsrc[1]  = r_bits[15:8];
        bsrc[2]  = r_bits[7:0];
        close_ok = 1'b0;
        invalid  = 1'b0;
        n_bits   = r_bits;
        n_sym    = r_sym;
        n_over   = r_over;
        if (!r_over) begin
            if (is_ws) begin
                // Whitespace is skipped.
            end else if (dec[6]) begin
                if (r_sym == 2'd3) begin
                    nb      = 2'd3;
                    bsrc[0] = grp[23:16];
                    bsrc[1] = grp[15:8];
                    bsrc[2] = grp[7:0];
                    n_bits  = 24'd0;
                    n_sym   = 2'd0;
                end else begin
                    n_bits = grp;
                    n_sym  = r_sym + 2'd1;
                end
            end else if (i_symbol == CH_EQ && r_sym[1]) begin
                nb       = (r_sym == 2'd3) ? 2'd2 : 2'd1;
                n_bits   = 24'd0;
                n_sym    = 2'd0;
                close_ok = 1'b1;
                n_over   = 1'b1;
            end else if (i_symbol == CH_NUL) begin
                close_ok = 1'b1;
                n_over   = 1'b1;
            end else begin
                invalid = 1'b1;
                n_over  = 1'b1;
            end
            // The last character closes a message that is still open.
            if (i_final_char && !n_over) begin
                close_ok = 1'b1;
            end
        end
        has_close = close_ok || invalid;
    end

    // Counter after each byte and whether the consumer still has room.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            cnt[k] = sat_add(r_count, 2'(k));
        end
        for (int k = 0; k < 3; k++) begin
            room[k] = (CMP_W'(cnt[k]) < CMP_W'(r_capacity)) && (2'(k) < nb);
        end
        // Room only falls as the count rises, so the kept bytes are a prefix.
        ne      = 2'(room[0]) + 2'(room[1]) + 2'(room[2]);
        c_after = cnt[nb];
        st_code = (CMP_W'(c_after) > CMP_W'(r_capacity)) ? STATUS_OVERFLOW : STATUS_OK;
    end

    // Pack the results of this character.
    always_comb begin
        o_cmd = '0;
        for (int k = 0; k < 4; k++) begin
            if (2'(k) < ne && k < 3) begin
                o_cmd.res[k].kind         = KIND_DATA;
                o_cmd.res[k].data_byte    = bsrc[k%3];
                o_cmd.res[k].status       = STATUS_OK;
                o_cmd.res[k].total_length = 16'(cnt[(k%3)+1]);
            end else if (3'(k) == {1'b0, ne} && has_close) begin
                o_cmd.res[k].kind         = KIND_STATUS;
                o_cmd.res[k].data_byte    = 8'd0;
                o_cmd.res[k].status       = invalid ? STATUS_INVALID : st_code;
                o_cmd.res[k].total_length = invalid ? 16'd0 : 16'(c_after);
            end
        end
        o_cmd.n = {1'b0, ne} + {2'b00, has_close};
    end

    assign o_cmd_push = accept && (o_cmd.n != 3'd0);
    assign n_count    = r_over ? r_count : c_after;

    // Message state; the last character returns it to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= 24'd0;
            r_sym   <= 2'd0;
            r_count <= '0;
            r_over  <= 1'b0;
        end else if (accept) begin
            if (i_final_char) begin
                r_bits  <= 24'd0;
                r_sym   <= 2'd0;
                r_count <= '0;
                r_over  <= 1'b0;
            end else begin
                r_bits  <= n_bits;
                r_sym   <= n_sym;
                r_count <= n_count;
                r_over  <= n_over;
            end
        end
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 16'hffff;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    `B64D_ASSERT_NEXT(a_final_clears, accept && i_final_char,
        r_count == '0 && r_sym == 2'd0 && !r_over, "final character did not clear state")
    `B64D_ASSERT_NOW(a_over_silent, accept && r_over, !o_cmd_push,
        "results produced after message end")

endmodule

`default_nettype wire

FILE: sv/b64d_cmd_queue.sv
// ----------------------------------------------------------------------------
// Base64 decoder command queue
// Short FIFO of per-character commands between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_top_defines.svh"

module b64d_cmd_queue import b64d_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_cmd    i_cmd,
    input  wire logic    i_pop,
    output      t_cmd    o_head,
    output      t_q_stat o_stat
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_PTR_W:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_stat.full  = (r_count == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `B64D_ASSERT_NOW(a_ptr_match, o_stat.empty, r_wr_ptr == r_rd_ptr,
        "queue empty but pointers differ")

endmodule

`default_nettype wire

FILE: sv/b64d_back.sv
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Walks head command results one per cycle to the output register as it drains.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_top_defines.svh"

module b64d_back import b64d_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_head,
    input  wire t_q_stat i_q_stat,
    input  wire logic    i_pop,
    output      logic    o_q_pop,
    output      logic    o_empty,
    output      t_result o_res,
    output      logic    o_last
);

    logic [1:0] r_sub;
    logic       r_out_valid;
    t_result    r_out;
    logic       r_last;
    logic       advance;
    logic       sub_last;

    // Move one result forward when the output register is free or drained.
    assign advance  = !i_q_stat.empty && (!r_out_valid || i_pop);
    assign sub_last = ({1'b0, r_sub} == (i_head.n - 3'd1));
    assign o_q_pop  = advance && sub_last;

    // Position within the head command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 2'd0;
        end else if (advance) begin
            r_sub <= sub_last ? 2'd0 : r_sub + 2'd1;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out  <= i_head.res[r_sub];
            r_last <= sub_last;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_res   = r_out;
    assign o_last  = r_last;

    `B64D_ASSERT_NOW(a_head_nonzero, !i_q_stat.empty, i_head.n != 3'd0,
        "queued command holds no results")
    `B64D_ASSERT_NOW(a_sub_range, !i_q_stat.empty, ({1'b0, r_sub} < i_head.n),
        "result index beyond command")

endmodule

`default_nettype wire

FILE: sv/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes a base64 character stream into data bytes plus a closing status.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: present i_symbol and i_final_char with push; a transfer
//   happens on a clock edge where push is high and full is low. One character
//   can transfer every cycle while full is low.
//   Result queue side: while empty is low the oldest result sits on o_kind,
//   o_data_byte, o_status, o_total_length and o_last; pop takes it.
//   Each character yields zero to four results, o_last marking its final one.
//   The first result of a character passes the command queue and then the
//   output register before it reaches the result ports, where pop takes it.
//   Results leave at one per cycle while pop is high and commands wait; the
//   output register and the back end's single-result serializer set that
//   rate, so a character's three or four results leave one at a time.
//   A four-entry command queue lets characters keep arriving while results
//   drain; when the receiver stalls, it fills and full rises.
//   Configuration: output capacity is written through i_cfg_valid with
//   i_cfg_data; o_cfg_ready is always high. Write it only while idle.
//   Reset (synchronous, i_rst_n low) clears the message state and queues and
//   sets the capacity to 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_top import b64d_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output      logic        full,
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_final_char,
    output      logic        empty,
    input  wire logic        pop,
    output      logic        o_kind,
    output      logic [7:0]  o_data_byte,
    output      logic [1:0]  o_status,
    output      logic [15:0] o_total_length,
    output      logic        o_last,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    t_q_stat q_stat;
    t_cmd    cmd;
    t_cmd    head;
    logic    cmd_push;
    logic    q_pop;
    t_result res;

    assign o_cfg_ready = 1'b1;
    assign full        = q_stat.full;

    // Front end: decode and classify.
    b64d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_symbol     (i_symbol),
        .i_final_char (i_final_char),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_q_stat     (q_stat),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd)
    );

    // Command queue between the two halves.
    b64d_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // Back end: serialize results.
    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .i_pop    (pop),
        .o_q_pop  (q_pop),
        .o_empty  (empty),
        .o_res    (res),
        .o_last   (o_last)
    );

    assign o_kind         = res.kind;
    assign o_data_byte    = res.data_byte;
    assign o_status       = res.status;
    assign o_total_length = res.total_length;

endmodule

`default_nettype wire
